/* rtl/hbkv_pkg.sv */
// Package with the constants, payload types and state encoding of the hash bucket table.
package hbkv_pkg;

    // The bucket count is a power of two, so the bucket is a slice of the key.
    localparam int BUCKET_COUNT    = 16;
    localparam int WAYS_PER_BUCKET = 4;
    localparam int KEY_BITS        = 32;
    localparam int VALUE_BITS      = 32;
    localparam int BUCKET_BITS     = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int WAY_BITS        = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_FULL = 1'b1
    } status_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [31:0]           default_result;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        found;
        logic        status;
    } out_item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } way_t;

    typedef way_t [WAYS_PER_BUCKET-1:0] row_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

endpackage

/* rtl/hbkv_row_ram.sv */
// Single-port-write, single-port-read RAM with a registered read.
module hbkv_row_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 256,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/hash_bucket_key_value_table.sv */
// Top level of the hash bucket key-value table.
// Each transaction first reads the bucket row from the row RAM, then compares
// the ways, writes the row back and loads the result register.
// out_valid rises after the row read and the compare state, which an unaccepted result
// can hold; a new transaction is accepted only in the idle state, after the last one is done.
// Reset clears all slot valid bits at once; keys and values are not cleared.
module hash_bucket_key_value_table
    import hbkv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    state_t    state_reg, state_next;
    in_item_t  req_reg;
    out_item_t out_data_reg, out_data_next;
    logic      out_valid_reg, out_valid_next;
    logic [WAYS_PER_BUCKET-1:0] valid_reg [BUCKET_COUNT];

    logic                   exec_done;
    logic [BUCKET_BITS-1:0] in_bucket, req_bucket, rd_addr;
    row_t                   rd_row, wr_row;
    logic                   wr_en;
    logic [WAYS_PER_BUCKET-1:0] row_valid;
    logic                   hit, has_free;
    logic [WAY_BITS-1:0]    hit_way, free_way;
    logic                   set_valid, clr_valid;
    logic [WAY_BITS-1:0]    upd_way;

    assign in_bucket  = BUCKET_BITS'(in_data.key % BUCKET_COUNT);
    assign req_bucket = BUCKET_BITS'(req_reg.key % BUCKET_COUNT);
    assign rd_addr    = (state_reg == ST_IDLE) ? in_bucket : req_bucket;
    assign row_valid  = valid_reg[req_bucket];

    hbkv_row_ram #(
        .DEPTH (BUCKET_COUNT),
        .WIDTH ($bits(row_t))
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (req_bucket),
        .wr_data (wr_row),
        .rd_addr (rd_addr),
        .rd_data (rd_row)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        exec_done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                exec_done = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        has_free = 1'b0;
        free_way = '0;
        for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--)
        begin
            if (row_valid[w] && (rd_row[w].key == req_reg.key))
            begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!row_valid[w])
            begin
                has_free = 1'b1;
                free_way = WAY_BITS'(w);
            end
        end
    end

    always_comb
    begin
        wr_row        = rd_row;
        wr_en         = 1'b0;
        set_valid     = 1'b0;
        clr_valid     = 1'b0;
        upd_way       = hit_way;
        out_data_next = '0;
        out_data_next.found  = hit;
        out_data_next.status = STATUS_OK;
        unique case (mode_t'(req_reg.mode))
            MODE_LOOKUP:
            begin
                out_data_next.result_value = hit ? rd_row[hit_way].value
                                                 : req_reg.default_result;
            end
            MODE_ADD:
            begin
                if (hit)
                begin
                    wr_row[hit_way].value = req_reg.value;
                    wr_en = exec_done;
                end
                else if (has_free)
                begin
                    upd_way                = free_way;
                    wr_row[free_way].key   = req_reg.key;
                    wr_row[free_way].value = req_reg.value;
                    wr_en     = exec_done;
                    set_valid = exec_done;
                end
                else
                begin
                    out_data_next.status = STATUS_FULL;
                end
            end
            MODE_REMOVE:
            begin
                clr_valid = exec_done && hit;
            end
            MODE_UNUSED:
            begin
                out_data_next.found = 1'b0;
            end
            default:
            begin
                out_data_next.found = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < BUCKET_COUNT; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (set_valid)
            begin
                valid_reg[req_bucket][upd_way] <= 1'b1;
            end
            else if (clr_valid)
            begin
                valid_reg[req_bucket][upd_way] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        if (exec_done)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* tb/sv/hash_bucket_key_value_table_tb.sv */
// Self-checking testbench for the hash bucket key-value table with a built-in predictor.
`timescale 1ns / 100ps

module hash_bucket_key_value_table_tb
    import hbkv_pkg::*;
();

    localparam int SLOT_TOTAL = BUCKET_COUNT * WAYS_PER_BUCKET;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    logic                  map_valid [SLOT_TOTAL];
    logic [KEY_BITS-1:0]   map_key   [SLOT_TOTAL];
    logic [VALUE_BITS-1:0] map_value [SLOT_TOTAL];

    logic [KEY_BITS-BUCKET_BITS-1:0] key_high_pool [8];

    out_item_t pending_results[$];

    bit idle_on = 1'b1;
    int stall_left = 0;
    int failures = 0;
    int results_seen = 0;
    int mode_count [4] = '{0, 0, 0, 0};
    int hit_count = 0;
    int full_count = 0;

    hash_bucket_key_value_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still outstanding", pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

    function automatic out_item_t apply_map_op(input in_item_t op);
        out_item_t res;
        int        base;
        int        hit;
        int        free_way;
        mode_t     m;
        m        = mode_t'(op.mode);
        base     = int'(op.key % BUCKET_COUNT) * WAYS_PER_BUCKET;
        hit      = -1;
        free_way = -1;
        res      = '0;
        for (int w = 0; w < WAYS_PER_BUCKET; w++)
        begin
            if (map_valid[base + w])
            begin
                if (hit < 0 && map_key[base + w] == op.key)
                    hit = w;
            end
            else if (free_way < 0)
            begin
                free_way = w;
            end
        end
        res.found = (hit >= 0);
        case (m)
            MODE_LOOKUP:
            begin
                res.result_value = (hit >= 0) ? map_value[base + hit] : op.default_result;
            end
            MODE_ADD:
            begin
                if (hit >= 0)
                begin
                    map_value[base + hit] = op.value;
                end
                else if (free_way >= 0)
                begin
                    map_valid[base + free_way] = 1'b1;
                    map_key[base + free_way]   = op.key;
                    map_value[base + free_way] = op.value;
                end
                else
                begin
                    res.status = STATUS_FULL;
                end
            end
            MODE_REMOVE:
            begin
                if (hit >= 0)
                    map_valid[base + hit] = 1'b0;
            end
            default:
            begin
                res.found = 1'b0;
            end
        endcase
        return res;
    endfunction

    task automatic note_failure(input string what, input out_item_t want);
        failures++;
        if (failures <= 10)
            $display("%0t: %s: expected value %08h found %0b status %0b, got %08h %0b %0b",
                     $time, what, want.result_value, want.found, want.status,
                     out_data.result_value, out_data.found, out_data.status);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                note_failure("Result with no transaction outstanding", '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.result_value !== want.result_value || out_data.found !== want.found
                    || out_data.status !== want.status)
                    note_failure("Result mismatch", want);
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(1, 19) - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_op(input mode_t m, input logic [KEY_BITS-1:0] k,
                           input logic [VALUE_BITS-1:0] v, input logic [31:0] d);
        in_item_t  op;
        out_item_t res;
        op.mode           = m;
        op.key            = k;
        op.value          = v;
        op.default_result = d;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= op;
        do
            @(posedge clk);
        while (!in_ready);
        res = apply_map_op(op);
        pending_results.insert(pending_results.size(), res);
        mode_count[m]++;
        if (res.found)
            hit_count++;
        if (res.status == STATUS_FULL)
            full_count++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key(input int lo_bucket, input int hi_bucket);
        logic [BUCKET_BITS-1:0] b;
        b = BUCKET_BITS'($urandom_range(lo_bucket, hi_bucket));
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return {key_high_pool[$urandom_range(0, 7)], b};
    endfunction

    function automatic mode_t pick_mode(input int add_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_weight)
            return MODE_ADD;
        else if (r < add_weight + 30)
            return MODE_LOOKUP;
        else if (r < 95)
            return MODE_REMOVE;
        return MODE_UNUSED;
    endfunction

    task automatic test_directed_cases();
        send_op(MODE_LOOKUP, 32'h0000_0000, 32'h0, 32'h0000_0000);
        send_op(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_op(MODE_REMOVE, 32'h0000_0000, 32'h0, 32'h0);
        send_op(MODE_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0);
        send_op(MODE_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(MODE_LOOKUP, 32'h0000_0000, 32'h0, 32'h0);
        send_op(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_op(MODE_ADD, 32'h0000_0000, 32'h5A5A_A5A5, 32'h0);
        send_op(MODE_LOOKUP, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF);
        // Fill every way of bucket 5, then try one more key in the same bucket.
        send_op(MODE_ADD, 32'd5, 32'h1111_1111, 32'h0);
        send_op(MODE_ADD, 32'd21, 32'h2222_2222, 32'h0);
        send_op(MODE_ADD, 32'd37, 32'h3333_3333, 32'h0);
        send_op(MODE_ADD, 32'd53, 32'h4444_4444, 32'h0);
        send_op(MODE_ADD, 32'd69, 32'h5555_5555, 32'h0);
        send_op(MODE_LOOKUP, 32'd69, 32'h0, 32'hDEAD_BEEF);
        // Freeing a middle way must let the next add reuse that way.
        send_op(MODE_REMOVE, 32'd21, 32'h0, 32'h0);
        send_op(MODE_ADD, 32'd69, 32'h6666_6666, 32'h0);
        send_op(MODE_LOOKUP, 32'd69, 32'h0, 32'h0);
        send_op(MODE_LOOKUP, 32'd37, 32'h0, 32'h0);
        send_op(MODE_REMOVE, 32'd99, 32'h0, 32'h0);
        send_op(MODE_UNUSED, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(MODE_UNUSED, 32'd7, 32'h1234_5678, 32'h0);
        send_op(MODE_REMOVE, 32'd5, 32'h0, 32'h0);
        send_op(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_op(MODE_LOOKUP, 32'd5, 32'h0, 32'hCAFE_F00D);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count)
            send_op(pick_mode(40), pick_key(0, BUCKET_COUNT - 1), $urandom, $urandom);
    endtask

    task automatic test_bucket_pressure(input int count);
        int b;
        b = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                b = $urandom_range(0, BUCKET_COUNT - 1);
            send_op(pick_mode(50), pick_key(b, b), $urandom, $urandom);
        end
    endtask

    task automatic test_back_to_back(input int count);
        repeat (count)
            send_op(pick_mode(40), pick_key(0, 3), $urandom, $urandom);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        key_high_pool[0] = '0;
        key_high_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            key_high_pool[i] = (KEY_BITS - BUCKET_BITS)'($urandom);
        for (int i = 0; i < SLOT_TOTAL; i++)
            map_valid[i] = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        wait_for_results();
        test_random_traffic(650);
        test_bucket_pressure(350);
        wait_for_results();
        idle_on = 1'b0;
        test_back_to_back(325);
        wait_for_results();
        repeat (8) @(posedge clk);

        failures += pending_results.size();
        $display("Ran %0d lookups, %0d adds, %0d removes and %0d unused-mode transactions.",
                 mode_count[MODE_LOOKUP], mode_count[MODE_ADD], mode_count[MODE_REMOVE],
                 mode_count[MODE_UNUSED]);
        $display("Checked %0d results: %0d key hits, %0d full-bucket refusals, %0d failures.",
                 results_seen, hit_count, full_count, failures);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/hbkv_pkg.sv
rtl/hbkv_row_ram.sv
rtl/hash_bucket_key_value_table.sv
tb/sv/hash_bucket_key_value_table_tb.sv
